>>> rtl/sbc_pkg.sv
// ----------------------------------------------------------------------------
// sbc_pkg
// shared types, constants and elaboration-time helpers for the stereo bus
// compressor
// ----------------------------------------------------------------------------
package sbc_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int SAMPLE_RATE     = 48000;

  localparam int ST_W   = 40;   // filter state word
  localparam int ACC_W  = 48;   // filter accumulator
  localparam int ENV_W  = 26;   // envelope, 2^-16 dB
  localparam int DB_W   = 22;   // level and curve values, 1/1024 dB
  localparam int MA_W   = 33;   // shared multiplier operand a
  localparam int MB_W   = 32;   // shared multiplier operand b
  localparam int PR_W   = MA_W + MB_W;

  localparam logic signed [ACC_W-1:0] ST_MAX = 48'sd549755813887;
  localparam logic signed [ACC_W-1:0] ST_MIN = -48'sd549755813888;

  localparam logic [ENV_W-1:0]       ENV_MAX      = 26'd67108863;
  localparam logic signed [DB_W-1:0] DB_FLOOR     = -22'sd122880;
  localparam logic signed [DB_W-1:0] DB_CAL       = 22'sd18432;
  localparam logic signed [DB_W-1:0] KNEE_HALF    = 22'sd5120;
  localparam logic [ENV_W-1:0]       GR_LIMIT     = 26'd1966080;
  localparam logic [31:0]            DB_PER_LOG2  = 32'd394566;
  localparam logic [31:0]            LOG2_PER_DB  = 32'd174165;
  localparam logic [31:0]            LN2_Q32      = 32'd2977044472;
  localparam logic [31:0]            DIV5_RECIP   = 32'd52429;
  localparam int                     EXP_TERMS    = 20;

  localparam logic signed [31:0] B0_RST = 32'sd267938850;
  localparam logic signed [31:0] B1_RST = -32'sd535877700;
  localparam logic signed [31:0] B2_RST = 32'sd267938850;
  localparam logic signed [31:0] A1_RST = -32'sd535876895;
  localparam logic signed [31:0] A2_RST = 32'sd267443319;
  localparam logic [15:0]        MAKEUP_RST = 16'd4096;

  typedef enum logic [2:0] {
    CFG_ENABLE, CFG_THRESH, CFG_MAKEUP, CFG_B0, CFG_B1, CFG_B2, CFG_A1, CFG_A2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    OP_B0, OP_B1, OP_A1, OP_B2, OP_A2
  } flt_op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FLT, ST_LVL, ST_NORM, ST_SQ, ST_DB, ST_CURVE, ST_KNEE,
    ST_ENV, ST_GAIN, ST_EXP, ST_DIV, ST_MK, ST_APP, ST_OUT
  } state_t;

  // e^-x in q32 by a 20 term series, elaboration only
  function automatic logic [63:0] exp_neg_c(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] sum;
    logic [63:0] term;
    x = x_in;
    if (x >= (64'd1 << 32)) x = (64'd1 << 32) - 64'd1;
    sum  = 64'd1 << 32;
    term = 64'd1 << 32;
    for (int i = 1; i <= EXP_TERMS; i++) begin
      term = ((term * x) >> 32) / 64'(i);
      if ((i % 2) == 1) sum = (term > sum) ? 64'd0 : sum - term;
      else sum = sum + term;
    end
    return sum;
  endfunction

  // one-pole coefficients, q0.32
  localparam logic [63:0] D_FA = 64'(SAMPLE_RATE) * 64'd1;
  localparam logic [63:0] D_FR = 64'(SAMPLE_RATE) * 64'd100;
  localparam logic [63:0] D_SA = 64'(SAMPLE_RATE) * 64'd300;
  localparam logic [63:0] D_SR = 64'(SAMPLE_RATE) * 64'd1500;
  localparam logic [63:0] X_FA = ((64'd1000 << 32) + D_FA / 2) / D_FA;
  localparam logic [63:0] X_FR = ((64'd1000 << 32) + D_FR / 2) / D_FR;
  localparam logic [63:0] X_SA = ((64'd1000 << 32) + D_SA / 2) / D_SA;
  localparam logic [63:0] X_SR = ((64'd1000 << 32) + D_SR / 2) / D_SR;
  localparam logic [31:0] K_FA = 32'((64'd1 << 32) - exp_neg_c(X_FA));
  localparam logic [31:0] K_FR = 32'((64'd1 << 32) - exp_neg_c(X_FR));
  localparam logic [31:0] K_SA = 32'((64'd1 << 32) - exp_neg_c(X_SA));
  localparam logic [31:0] K_SR = 32'((64'd1 << 32) - exp_neg_c(X_SR));

  function automatic logic signed [ST_W-1:0] sat40(input logic signed [ACC_W-1:0] v);
    if (v > ST_MAX) return ST_MAX[ST_W-1:0];
    if (v < ST_MIN) return ST_MIN[ST_W-1:0];
    return v[ST_W-1:0];
  endfunction

  function automatic logic [ENV_W-1:0] gr_to_target(input logic [DB_W-1:0] gr);
    if (gr > DB_W'(ENV_MAX >> 6)) return ENV_MAX;
    return ENV_W'(gr) << 6;
  endfunction

endpackage

>>> rtl/stereo_bus_compressor.sv
// ----------------------------------------------------------------------------
// stereo_bus_compressor
// feedforward 4:1 soft-knee stereo bus compressor, fast and slow envelopes
// ----------------------------------------------------------------------------
// One stereo item goes in, one item comes out. While enabled, every product
// of the sidechain biquads, the level log (sixteen squarings), the knee, both
// envelopes, the 20-term exponential and the output gain runs through a single
// 33x32 multiplier with a registered product, and each series term also needs
// a divide at 4 bits a cycle. The level normalize shifts one bit a cycle, so
// quiet signals need more shifts. With enable low an item skips the sidechain
// and goes straight from idle to the output state. in_ready is high only
// while the sequencer is idle; a finished item waits in the output register,
// so the next item can be taken before the previous one is read. The
// configuration port is always ready and must only be written while idle.
module stereo_bus_compressor
  import sbc_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_left_in,
  input  logic signed [SAMPLE_BITS-1:0] in_right_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_left_out,
  output logic signed [SAMPLE_BITS-1:0] out_right_out,
  output logic [14:0]                   out_gain_reduction,
  output logic                          out_clipped,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [2:0]                    cfg_index,
  input  logic [31:0]                   cfg_data
);

  localparam int SB = SAMPLE_BITS;
  // log2 offset of full scale: sample width plus the 8 guard bits, minus one
  localparam logic signed [23:0] LOG_OFS = 24'((SB + 7) * 65536);
  localparam logic signed [38:0] SAMP_HI = 39'((64'd1 << (SB - 1)) - 64'd1);
  localparam logic signed [38:0] SAMP_LO = -SAMP_HI - 39'sd1;

  // configuration registers
  logic                enable_r;
  logic signed [12:0]  thresh_r;
  logic [15:0]         makeup_r;
  logic signed [31:0]  b0_r, b1_r, b2_r, a1_r, a2_r;

  // sequencer
  state_t state_r, state_nxt;
  logic       ch_r, ch_nxt;          // channel, or envelope select
  flt_op_t    op_r, op_nxt;          // biquad product
  logic [1:0] ph_r, ph_nxt;          // phase within a step
  logic [4:0] cnt_r, cnt_nxt;        // squaring count, series index
  logic [2:0] dcnt_r, dcnt_nxt;      // divide cycles

  // datapath registers
  logic signed [SB-1:0]    x_r [2];
  logic signed [SB-1:0]    x_nxt [2];
  logic signed [ST_W-1:0]  s0_r [2];
  logic signed [ST_W-1:0]  s0_nxt [2];
  logic signed [ST_W-1:0]  s1_r [2];
  logic signed [ST_W-1:0]  s1_nxt [2];
  logic signed [ST_W-1:0]  y_r [2];
  logic signed [ST_W-1:0]  y_nxt [2];
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [43:0]             tmp_r, tmp_nxt;
  logic [39:0]             norm_r, norm_nxt;
  logic [5:0]              sh_r, sh_nxt;
  logic [30:0]             m_r, m_nxt;
  logic [15:0]             frac_r, frac_nxt;
  logic signed [DB_W-1:0]  db_r, db_nxt;
  logic [ENV_W-1:0]        target_r, target_nxt;
  logic [ENV_W-1:0]        fast_r, fast_nxt;
  logic [ENV_W-1:0]        slow_r, slow_nxt;
  logic [14:0]             gr_r, gr_nxt;
  logic [3:0]              ip_r, ip_nxt;
  logic [31:0]             xe_r, xe_nxt;
  logic [31:0]             term_r, term_nxt;
  logic [33:0]             sum_r, sum_nxt;
  logic [31:0]             dv_r, dv_nxt;
  logic [4:0]              rem_r, rem_nxt;
  logic [MA_W-1:0]         g28_r, g28_nxt;
  logic signed [SB-1:0]    lo_r, lo_nxt, ro_r, ro_nxt;
  logic                    clip_r, clip_nxt;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic signed [SB-1:0] out_l_r, out_l_nxt, out_r_r, out_r_nxt;
  logic [14:0]          out_gr_r, out_gr_nxt;
  logic                 out_clip_r, out_clip_nxt;

  // shared multiplier
  logic [MA_W-1:0] mul_a;
  logic [MB_W-1:0] mul_b;
  logic [PR_W-1:0] prod_r;

  // ---------------------------------------------------------------------------
  // biquad product terms: |coef| * |value| split into a high and low half
  // ---------------------------------------------------------------------------
  logic signed [31:0]      coef_c;
  logic signed [ST_W-1:0]  xq_c, v_c;
  logic [31:0]             uc_c;
  logic [39:0]             uv_c;
  logic                    neg_c;
  logic [44:0]             mr_c;
  logic signed [ACC_W-1:0] m_c;

  always_comb begin
    unique case (op_r)
      OP_B0:   coef_c = b0_r;
      OP_B1:   coef_c = b1_r;
      OP_A1:   coef_c = a1_r;
      OP_B2:   coef_c = b2_r;
      OP_A2:   coef_c = a2_r;
      default: coef_c = b0_r;
    endcase
  end

  assign xq_c  = ST_W'(x_r[ch_r]) <<< 8;
  assign v_c   = (op_r == OP_A1 || op_r == OP_A2) ? y_r[ch_r] : xq_c;
  assign uc_c  = coef_c[31] ? 32'(-coef_c) : 32'(coef_c);
  assign uv_c  = v_c[ST_W-1] ? 40'(-v_c) : 40'(v_c);
  assign neg_c = coef_c[31] ^ v_c[ST_W-1];
  assign mr_c  = {1'b0, tmp_r} + 45'(prod_r[63:28]);
  assign m_c   = neg_c ? -$signed(ACC_W'(mr_c)) : $signed(ACC_W'(mr_c));

  // ---------------------------------------------------------------------------
  // level, log and curve terms
  // ---------------------------------------------------------------------------
  logic [39:0]             ay0_c, ay1_c, lvl_c;
  logic [21:0]             ld_c;
  logic signed [23:0]      d_c;
  logic [22:0]             ad_c;
  logic [40:0]             vdb_c;
  logic signed [DB_W-1:0]  dbv_c, dbc_c;
  logic signed [DB_W-1:0]  thr_c, over_c;
  logic [23:0]             lin_c;
  logic [31:0]             mm_c;

  assign ay0_c = y_r[0][ST_W-1] ? 40'(-y_r[0]) : 40'(y_r[0]);
  assign ay1_c = y_r[1][ST_W-1] ? 40'(-y_r[1]) : 40'(y_r[1]);
  assign lvl_c = (ay0_c > ay1_c) ? ay0_c : ay1_c;
  assign mm_c  = prod_r[61:30];

  assign ld_c  = {6'd39 - sh_r, frac_r};
  assign d_c   = $signed({2'b00, ld_c}) - LOG_OFS;
  assign ad_c  = d_c[23] ? 23'(-d_c) : 23'(d_c);
  assign vdb_c = prod_r[40:0];
  // floor of the signed product over 2^22
  assign dbv_c = d_c[23] ? -$signed(DB_W'((vdb_c - 41'd1) >> 22)) - 22'sd1
                         : $signed(DB_W'(vdb_c >> 22));
  assign dbc_c = ((dbv_c < DB_FLOOR) ? DB_FLOOR : dbv_c) + DB_CAL;

  assign thr_c  = DB_W'(thresh_r);
  assign over_c = db_r - (thr_c <<< 2);
  assign lin_c  = 24'(over_c) + 24'({over_c, 1'b0});

  // ---------------------------------------------------------------------------
  // envelopes and gain
  // ---------------------------------------------------------------------------
  logic [ENV_W-1:0] env_c, diff_c, envm_c, envc_c;
  logic [31:0]      k_c;
  logic             up_c;
  logic [ENV_W-1:0] delta_c;
  logic [32:0]      g32_c;

  assign env_c   = ch_r ? slow_r : fast_r;
  assign up_c    = target_r >= env_c;
  assign diff_c  = up_c ? target_r - env_c : env_c - target_r;
  assign k_c     = (target_r > env_c) ? (ch_r ? K_SA : K_FA) : (ch_r ? K_SR : K_FR);
  assign delta_c = prod_r[57:32];
  assign envm_c  = (fast_r > slow_r) ? fast_r : slow_r;
  assign envc_c  = (envm_c > GR_LIMIT) ? GR_LIMIT : envm_c;
  assign g32_c   = 33'(sum_r >> ip_r);

  // output sample terms
  logic signed [32:0] xs_c;
  logic [31:0]        mag_c;
  logic [65:0]        rnd_c;
  logic signed [38:0] r_c;

  assign xs_c  = 33'(x_r[ch_r]);
  assign mag_c = xs_c[32] ? 32'(-xs_c) : 32'(xs_c);
  assign rnd_c = {1'b0, prod_r} + 66'(64'd1 << 27);
  assign r_c   = x_r[ch_r][SB-1] ? -$signed({1'b0, rnd_c[65:28]})
                                  : $signed({1'b0, rnd_c[65:28]});

  // ---------------------------------------------------------------------------
  // series divide: 4 quotient bits a cycle, divisor is the term index
  // ---------------------------------------------------------------------------
  logic [31:0] dv_step;
  logic [4:0]  rem_step;

  always_comb begin : div_step
    logic [31:0] dv;
    logic [4:0]  rem;
    logic [5:0]  r6;
    dv  = dv_r;
    rem = rem_r;
    for (int j = 0; j < 4; j++) begin
      r6 = {rem, dv[31]};
      dv = {dv[30:0], 1'b0};
      if (r6 >= {1'b0, cnt_r}) begin
        rem   = 5'(r6 - {1'b0, cnt_r});
        dv[0] = 1'b1;
      end else begin
        rem = r6[4:0];
      end
    end
    dv_step  = dv;
    rem_step = rem;
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt  = state_r;
    ch_nxt     = ch_r;
    op_nxt     = op_r;
    ph_nxt     = ph_r;
    cnt_nxt    = cnt_r;
    dcnt_nxt   = dcnt_r;
    x_nxt      = x_r;
    s0_nxt     = s0_r;
    s1_nxt     = s1_r;
    y_nxt      = y_r;
    acc_nxt    = acc_r;
    tmp_nxt    = tmp_r;
    norm_nxt   = norm_r;
    sh_nxt     = sh_r;
    m_nxt      = m_r;
    frac_nxt   = frac_r;
    db_nxt     = db_r;
    target_nxt = target_r;
    fast_nxt   = fast_r;
    slow_nxt   = slow_r;
    gr_nxt     = gr_r;
    ip_nxt     = ip_r;
    xe_nxt     = xe_r;
    term_nxt   = term_r;
    sum_nxt    = sum_r;
    dv_nxt     = dv_r;
    rem_nxt    = rem_r;
    g28_nxt    = g28_r;
    lo_nxt     = lo_r;
    ro_nxt     = ro_r;
    clip_nxt   = clip_r;
    mul_a      = '0;
    mul_b      = '0;

    out_valid_nxt = out_valid_r && !out_ready;
    out_l_nxt     = out_l_r;
    out_r_nxt     = out_r_r;
    out_gr_nxt    = out_gr_r;
    out_clip_nxt  = out_clip_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          x_nxt[0] = in_left_in;
          x_nxt[1] = in_right_in;
          clip_nxt = 1'b0;
          if (enable_r) begin
            ch_nxt    = 1'b0;
            op_nxt    = OP_B0;
            ph_nxt    = 2'd0;
            state_nxt = ST_FLT;
          end else begin
            lo_nxt    = in_left_in;
            ro_nxt    = in_right_in;
            gr_nxt    = '0;
            state_nxt = ST_OUT;
          end
        end
      end

      ST_FLT: begin
        mul_a = MA_W'(uc_c);
        unique case (ph_r)
          2'd0: begin
            mul_b  = MB_W'(uv_c[39:32]);
            ph_nxt = 2'd1;
          end
          2'd1: begin
            mul_b   = uv_c[31:0];
            tmp_nxt = {prod_r[39:0], 4'd0};
            ph_nxt  = 2'd2;
          end
          default: begin
            ph_nxt = 2'd0;
            unique case (op_r)
              OP_B0: y_nxt[ch_r]  = sat40(m_c + ACC_W'(s0_r[ch_r]));
              OP_B1: acc_nxt      = m_c + ACC_W'(s1_r[ch_r]);
              OP_A1: s0_nxt[ch_r] = sat40(acc_r - m_c);
              OP_B2: acc_nxt      = m_c;
              default: s1_nxt[ch_r] = sat40(acc_r - m_c);
            endcase
            if (op_r == OP_A2) begin
              op_nxt = OP_B0;
              if (ch_r) begin
                ch_nxt    = 1'b0;
                state_nxt = ST_LVL;
              end else begin
                ch_nxt = 1'b1;
              end
            end else begin
              op_nxt = flt_op_t'(op_r + 3'd1);
            end
          end
        endcase
      end

      ST_LVL: begin
        if (lvl_c == '0) begin
          db_nxt    = DB_FLOOR + DB_CAL;
          state_nxt = ST_CURVE;
        end else begin
          norm_nxt  = lvl_c;
          sh_nxt    = '0;
          state_nxt = ST_NORM;
        end
      end

      ST_NORM: begin
        if (norm_r[39]) begin
          m_nxt     = norm_r[39:9];
          frac_nxt  = '0;
          cnt_nxt   = '0;
          ph_nxt    = 2'd0;
          state_nxt = ST_SQ;
        end else begin
          norm_nxt = {norm_r[38:0], 1'b0};
          sh_nxt   = sh_r + 6'd1;
        end
      end

      ST_SQ: begin
        if (ph_r == 2'd0) begin
          mul_a  = MA_W'(m_r);
          mul_b  = MB_W'(m_r);
          ph_nxt = 2'd1;
        end else begin
          if (mm_c[31]) begin
            m_nxt    = mm_c[31:1];
            frac_nxt = {frac_r[14:0], 1'b1};
          end else begin
            m_nxt    = mm_c[30:0];
            frac_nxt = {frac_r[14:0], 1'b0};
          end
          ph_nxt = 2'd0;
          if (cnt_r == 5'd15) state_nxt = ST_DB;
          else cnt_nxt = cnt_r + 5'd1;
        end
      end

      ST_DB: begin
        if (ph_r == 2'd0) begin
          mul_a  = MA_W'(ad_c);
          mul_b  = DB_PER_LOG2;
          ph_nxt = 2'd1;
        end else begin
          db_nxt    = dbc_c;
          ph_nxt    = 2'd0;
          state_nxt = ST_CURVE;
        end
      end

      ST_CURVE: begin
        ph_nxt = 2'd0;
        ch_nxt = 1'b0;
        if (over_c <= -KNEE_HALF) begin
          target_nxt = '0;
          state_nxt  = ST_ENV;
        end else if (over_c >= KNEE_HALF) begin
          target_nxt = gr_to_target(DB_W'(lin_c >> 2));
          state_nxt  = ST_ENV;
        end else begin
          tmp_nxt   = 44'(14'(over_c + KNEE_HALF));
          state_nxt = ST_KNEE;
        end
      end

      // 3*u*u/81920 as ((3*u*u) >> 14) / 5, the divide by reciprocal
      ST_KNEE: begin
        unique case (ph_r)
          2'd0: begin
            mul_a  = MA_W'(tmp_r[13:0]);
            mul_b  = MB_W'(tmp_r[13:0]);
            ph_nxt = 2'd1;
          end
          2'd1: begin
            tmp_nxt = 44'((30'(prod_r[27:0]) + 30'({prod_r[27:0], 1'b0})) >> 14);
            ph_nxt  = 2'd2;
          end
          2'd2: begin
            mul_a  = MA_W'(tmp_r[15:0]);
            mul_b  = DIV5_RECIP;
            ph_nxt = 2'd3;
          end
          default: begin
            target_nxt = gr_to_target(DB_W'(prod_r[33:18]));
            ph_nxt     = 2'd0;
            state_nxt  = ST_ENV;
          end
        endcase
      end

      ST_ENV: begin
        if (ph_r == 2'd0) begin
          mul_a  = MA_W'(diff_c);
          mul_b  = k_c;
          ph_nxt = 2'd1;
        end else begin
          ph_nxt = 2'd0;
          if (ch_r) begin
            slow_nxt  = up_c ? slow_r + delta_c : slow_r - delta_c;
            ch_nxt    = 1'b0;
            state_nxt = ST_GAIN;
          end else begin
            fast_nxt = up_c ? fast_r + delta_c : fast_r - delta_c;
            ch_nxt   = 1'b1;
          end
        end
      end

      // log2 of attenuation, then 2^-frac through e^-(frac*ln2)
      ST_GAIN: begin
        unique case (ph_r)
          2'd0: begin
            gr_nxt = envc_c[20:6];
            mul_a  = MA_W'(envc_c);
            mul_b  = LOG2_PER_DB;
            ph_nxt = 2'd1;
          end
          2'd1: begin
            ip_nxt  = 4'(prod_r[38:36]);
            tmp_nxt = 44'(prod_r[35:20]);
            ph_nxt  = 2'd2;
          end
          2'd2: begin
            mul_a  = MA_W'(tmp_r[15:0]);
            mul_b  = LN2_Q32;
            ph_nxt = 2'd3;
          end
          default: begin
            xe_nxt    = prod_r[47:16];
            term_nxt  = prod_r[47:16];
            sum_nxt   = 34'(64'd1 << 32) - 34'(prod_r[47:16]);
            cnt_nxt   = 5'd2;
            ph_nxt    = 2'd0;
            state_nxt = ST_EXP;
          end
        endcase
      end

      ST_EXP: begin
        if (ph_r == 2'd0) begin
          mul_a  = MA_W'(term_r);
          mul_b  = xe_r;
          ph_nxt = 2'd1;
        end else begin
          dv_nxt    = prod_r[63:32];
          rem_nxt   = '0;
          dcnt_nxt  = '0;
          ph_nxt    = 2'd0;
          state_nxt = ST_DIV;
        end
      end

      ST_DIV: begin
        dv_nxt   = dv_step;
        rem_nxt  = rem_step;
        dcnt_nxt = dcnt_r + 3'd1;
        if (dcnt_r == 3'd7) begin
          term_nxt = dv_step;
          // odd terms subtract, clamped at zero
          if (cnt_r[0]) sum_nxt = (34'(dv_step) > sum_r) ? '0 : sum_r - 34'(dv_step);
          else sum_nxt = sum_r + 34'(dv_step);
          if (cnt_r == 5'(EXP_TERMS)) begin
            state_nxt = ST_MK;
          end else begin
            cnt_nxt   = cnt_r + 5'd1;
            state_nxt = ST_EXP;
          end
        end
      end

      ST_MK: begin
        if (ph_r == 2'd0) begin
          mul_a  = g32_c;
          mul_b  = MB_W'(makeup_r);
          ph_nxt = 2'd1;
        end else begin
          g28_nxt   = prod_r[48:16];
          ch_nxt    = 1'b0;
          ph_nxt    = 2'd0;
          state_nxt = ST_APP;
        end
      end

      ST_APP: begin
        if (ph_r == 2'd0) begin
          mul_a  = g28_r;
          mul_b  = mag_c;
          ph_nxt = 2'd1;
        end else begin
          logic signed [SB-1:0] res;
          res = SB'(r_c);
          if (r_c > SAMP_HI) begin
            res      = SB'(SAMP_HI);
            clip_nxt = 1'b1;
          end else if (r_c < SAMP_LO) begin
            res      = SB'(SAMP_LO);
            clip_nxt = 1'b1;
          end
          if (ch_r) ro_nxt = res;
          else lo_nxt = res;
          ph_nxt = 2'd0;
          if (ch_r) begin
            ch_nxt    = 1'b0;
            state_nxt = ST_OUT;
          end else begin
            ch_nxt = 1'b1;
          end
        end
      end

      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_l_nxt     = lo_r;
          out_r_nxt     = ro_r;
          out_gr_nxt    = gr_r;
          out_clip_nxt  = clip_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      s0_r[0]     <= '0;
      s0_r[1]     <= '0;
      s1_r[0]     <= '0;
      s1_r[1]     <= '0;
      fast_r      <= '0;
      slow_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      s0_r        <= s0_nxt;
      s1_r        <= s1_nxt;
      fast_r      <= fast_nxt;
      slow_r      <= slow_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r     <= PR_W'(mul_a) * PR_W'(mul_b);
    ch_r       <= ch_nxt;
    op_r       <= op_nxt;
    ph_r       <= ph_nxt;
    cnt_r      <= cnt_nxt;
    dcnt_r     <= dcnt_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    acc_r      <= acc_nxt;
    tmp_r      <= tmp_nxt;
    norm_r     <= norm_nxt;
    sh_r       <= sh_nxt;
    m_r        <= m_nxt;
    frac_r     <= frac_nxt;
    db_r       <= db_nxt;
    target_r   <= target_nxt;
    gr_r       <= gr_nxt;
    ip_r       <= ip_nxt;
    xe_r       <= xe_nxt;
    term_r     <= term_nxt;
    sum_r      <= sum_nxt;
    dv_r       <= dv_nxt;
    rem_r      <= rem_nxt;
    g28_r      <= g28_nxt;
    lo_r       <= lo_nxt;
    ro_r       <= ro_nxt;
    clip_r     <= clip_nxt;
    out_l_r    <= out_l_nxt;
    out_r_r    <= out_r_nxt;
    out_gr_r   <= out_gr_nxt;
    out_clip_r <= out_clip_nxt;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      thresh_r <= '0;
      makeup_r <= MAKEUP_RST;
      b0_r     <= B0_RST;
      b1_r     <= B1_RST;
      b2_r     <= B2_RST;
      a1_r     <= A1_RST;
      a2_r     <= A2_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ENABLE: enable_r <= cfg_data[0];
        CFG_THRESH: thresh_r <= cfg_data[12:0];
        CFG_MAKEUP: makeup_r <= cfg_data[15:0];
        CFG_B0:     b0_r     <= cfg_data;
        CFG_B1:     b1_r     <= cfg_data;
        CFG_B2:     b2_r     <= cfg_data;
        CFG_A1:     a1_r     <= cfg_data;
        CFG_A2:     a2_r     <= cfg_data;
        default:    enable_r <= enable_r;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_left_out       = out_l_r;
  assign out_right_out      = out_r_r;
  assign out_gain_reduction = out_gr_r;
  assign out_clipped        = out_clip_r;

endmodule
